### sv/ctb_pkg.sv
package ctb_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH) + 1;
  localparam int CMD_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 10;
  localparam int OUT_W   = 11;
  localparam int STAT_W  = 2;
  localparam int WIDE_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } ctb_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_BOUND = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } ctb_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DATA,
    S_RESP
  } ctb_state_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } ctb_mem_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [OUT_W-1:0]  text_length;
    logic [OUT_W-1:0]  cursor_pos;
    ctb_status_t       status;
  } ctb_res_t;

endpackage

### sv/ctb_if.sv
interface ctb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ctb_pkg::CMD_W-1:0]     cmd;
  logic [ctb_pkg::CHAR_W-1:0]    char_in;
  logic [ctb_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, cmd, char_in, read_index, input ready);
  modport sink   (input valid, cmd, char_in, read_index, output ready);
endinterface

interface ctb_out_if;
  logic                          valid;
  logic                          ready;
  logic [ctb_pkg::CHAR_W-1:0]    char_out;
  logic [ctb_pkg::OUT_W-1:0]     text_length;
  logic [ctb_pkg::OUT_W-1:0]     cursor_pos;
  logic [ctb_pkg::STAT_W-1:0]    status;

  modport source (output valid, char_out, text_length, cursor_pos, status, input ready);
  modport sink   (input valid, char_out, text_length, cursor_pos, status, output ready);
endinterface

### sv/ctb_ram.sv
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### sv/ctb_ctrl.sv
module ctb_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  ctb_in_if.sink                     in_ch,
  output ctb_pkg::ctb_mem_req_t      mem_req_o,
  input  logic [ctb_pkg::CHAR_W-1:0] mem_rdata_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ctb_pkg::ctb_res_t          res_o
);

  ctb_pkg::ctb_state_t            state_r, state_nxt;
  ctb_pkg::ctb_cmd_t              cmd_r, cmd_nxt;
  logic [ctb_pkg::CHAR_W-1:0]     char_r, char_nxt;
  logic [ctb_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [ctb_pkg::CHAR_W-1:0]     rdch_r, rdch_nxt;
  ctb_pkg::ctb_status_t           status_r, status_nxt;
  logic [ctb_pkg::CNT_W-1:0]      left_r, left_nxt;
  logic [ctb_pkg::CNT_W-1:0]      right_r, right_nxt;

  logic [ctb_pkg::CNT_W-1:0]      len;
  logic                           full;
  logic                           idx_ok;
  logic                           idx_left;
  logic                           in_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign len      = left_r + right_r;
  assign full     = (len == ctb_pkg::CNT_W'(ctb_pkg::DEPTH));
  assign idx_ok   = ctb_pkg::WIDE_W'(idx_r) < ctb_pkg::WIDE_W'(len);
  assign idx_left = ctb_pkg::WIDE_W'(idx_r) < ctb_pkg::WIDE_W'(left_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ctb_pkg::S_IDLE: begin
        if (in_fire) state_nxt = ctb_pkg::S_EXEC;
      end
      ctb_pkg::S_EXEC: begin
        state_nxt = ctb_pkg::S_RESP;
        case (cmd_r)
          ctb_pkg::CMD_LEFT:  if (left_r != '0) state_nxt = ctb_pkg::S_DATA;
          ctb_pkg::CMD_RIGHT: if (right_r != '0) state_nxt = ctb_pkg::S_DATA;
          ctb_pkg::CMD_READ:  if (idx_ok) state_nxt = ctb_pkg::S_DATA;
          default: ;
        endcase
      end
      ctb_pkg::S_DATA: state_nxt = ctb_pkg::S_RESP;
      ctb_pkg::S_RESP: begin
        if (res_ready_i) state_nxt = ctb_pkg::S_IDLE;
      end
      default: state_nxt = ctb_pkg::S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    cmd_nxt    = cmd_r;
    char_nxt   = char_r;
    idx_nxt    = idx_r;
    rdch_nxt   = rdch_r;
    status_nxt = status_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    mem_req_o  = '0;
    case (state_r)
      ctb_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = ctb_pkg::ctb_cmd_t'(in_ch.cmd);
          char_nxt = in_ch.char_in;
          idx_nxt  = in_ch.read_index;
        end
      end
      ctb_pkg::S_EXEC: begin
        rdch_nxt   = '0;
        status_nxt = ctb_pkg::ST_DONE;
        case (cmd_r)
          ctb_pkg::CMD_INSERT: begin
            if (full) begin
              status_nxt = ctb_pkg::ST_FULL;
            end else begin
              mem_req_o.en    = 1'b1;
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = ctb_pkg::ADDR_W'(left_r);
              mem_req_o.wdata = char_r;
              left_nxt        = left_r + 1'b1;
            end
          end
          ctb_pkg::CMD_LEFT: begin
            if (left_r == '0) begin
              status_nxt = ctb_pkg::ST_BOUND;
            end else begin
              mem_req_o.en   = 1'b1;
              mem_req_o.addr = ctb_pkg::ADDR_W'(left_r - 1'b1);
            end
          end
          ctb_pkg::CMD_RIGHT: begin
            if (right_r == '0) begin
              status_nxt = ctb_pkg::ST_BOUND;
            end else begin
              mem_req_o.en   = 1'b1;
              mem_req_o.addr = ctb_pkg::ADDR_W'(ctb_pkg::CNT_W'(ctb_pkg::DEPTH) - right_r);
            end
          end
          ctb_pkg::CMD_DELETE: begin
            if (left_r == '0) status_nxt = ctb_pkg::ST_BOUND;
            else left_nxt = left_r - 1'b1;
          end
          ctb_pkg::CMD_READ: begin
            if (!idx_ok) begin
              status_nxt = ctb_pkg::ST_RANGE;
            end else begin
              mem_req_o.en = 1'b1;
              // right-hand text starts at the top of the gap
              if (idx_left) begin
                mem_req_o.addr = ctb_pkg::ADDR_W'(idx_r);
              end else begin
                mem_req_o.addr = ctb_pkg::ADDR_W'(ctb_pkg::CNT_W'(ctb_pkg::DEPTH) - len
                                                  + ctb_pkg::CNT_W'(idx_r));
              end
            end
          end
          default: ;
        endcase
      end
      ctb_pkg::S_DATA: begin
        case (cmd_r)
          ctb_pkg::CMD_LEFT: begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = ctb_pkg::ADDR_W'(ctb_pkg::CNT_W'(ctb_pkg::DEPTH)
                                               - right_r - 1'b1);
            mem_req_o.wdata = mem_rdata_i;
            left_nxt        = left_r - 1'b1;
            right_nxt       = right_r + 1'b1;
          end
          ctb_pkg::CMD_RIGHT: begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = ctb_pkg::ADDR_W'(left_r);
            mem_req_o.wdata = mem_rdata_i;
            left_nxt        = left_r + 1'b1;
            right_nxt       = right_r - 1'b1;
          end
          ctb_pkg::CMD_READ: rdch_nxt = mem_rdata_i;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctb_pkg::S_IDLE;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    char_r   <= char_nxt;
    idx_r    <= idx_nxt;
    rdch_r   <= rdch_nxt;
    status_r <= status_nxt;
  end

  assign in_ch.ready       = (state_r == ctb_pkg::S_IDLE);
  assign res_valid_o       = (state_r == ctb_pkg::S_RESP);
  assign res_o.char_out    = rdch_r;
  assign res_o.text_length = ctb_pkg::OUT_W'(len);
  assign res_o.cursor_pos  = ctb_pkg::OUT_W'(left_r);
  assign res_o.status      = status_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctb_pkg::WIDE_W'(left_r) + ctb_pkg::WIDE_W'(right_r))
      <= ctb_pkg::WIDE_W'(ctb_pkg::DEPTH))
    else $error("text length exceeds store depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ctb_pkg::S_EXEC)
    else $error("accepted command not executed next cycle");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req_o.en && mem_req_o.we) |->
      (state_r == ctb_pkg::S_EXEC || state_r == ctb_pkg::S_DATA))
    else $error("store written outside execute phase");

  a_counts_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctb_pkg::S_RESP || state_r == ctb_pkg::S_IDLE) |=>
      $stable(left_r) && $stable(right_r))
    else $error("counts changed while not executing");

endmodule

### sv/cursor_text_buffer.sv
// insert, delete, failed moves and bad reads go from execute straight to response; cursor moves
//   and reads add a data state, as they wait on the store's registered read data
// a new command is taken only once the last result has left the response state; a move
//   reads and then writes the single-port store to carry one character across the gap
// reset: cursor and counts cleared, store contents left as they are, no clearing pass
module cursor_text_buffer (
  input  logic        clk,
  input  logic        rst_n,
  ctb_in_if.sink      in_ch,
  ctb_out_if.source   out_ch
);

  ctb_pkg::ctb_mem_req_t       mem_req;
  logic [ctb_pkg::CHAR_W-1:0]  mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  ctb_pkg::ctb_res_t           res;

  logic                        out_valid_r, out_valid_nxt;
  ctb_pkg::ctb_res_t           out_r, out_nxt;

  ctb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ctb_ram #(
    .WIDTH (ctb_pkg::CHAR_W),
    .DEPTH (ctb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // output register frees once its result transfers
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_out    = out_r.char_out;
  assign out_ch.text_length = out_r.text_length;
  assign out_ch.cursor_pos  = out_r.cursor_pos;
  assign out_ch.status      = out_r.status;

endmodule

### tb/sv/cursor_text_buffer_tb.sv
module cursor_text_buffer_tb;
  import ctb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;
  localparam int unsigned DRAIN_AT  = 300;
  localparam int unsigned HOLD_AT   = 60;
  localparam int unsigned HOLD_LEN  = 250;
  localparam int unsigned TAIL_CYC  = 20;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } edit_t;

  logic clk = 1'b0;
  logic rst_n;

  ctb_in_if  in_ch();
  ctb_out_if out_ch();

  cursor_text_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow gap buffer
  logic [CHAR_W-1:0] shadow_text [DEPTH];
  int unsigned left_n;
  int unsigned right_n;

  edit_t       cmd_queue[$];
  ctb_res_t    pending_results[$];
  edit_t       live_item;
  int unsigned total_items;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hold_cycles;
  int unsigned errors;

  function automatic void predict_edit(edit_t e);
    ctb_res_t    r;
    int unsigned len;
    len = left_n + right_n;
    r = '0;
    r.status = ST_DONE;
    case (e.cmd)
      CMD_INSERT: begin
        if (len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_text[left_n] = e.ch;
          left_n++;
        end
      end
      CMD_LEFT: begin
        if (left_n == 0) begin
          r.status = ST_BOUND;
        end else begin
          shadow_text[DEPTH - right_n - 1] = shadow_text[left_n - 1];
          left_n--;
          right_n++;
        end
      end
      CMD_RIGHT: begin
        if (right_n == 0) begin
          r.status = ST_BOUND;
        end else begin
          shadow_text[left_n] = shadow_text[DEPTH - right_n];
          left_n++;
          right_n--;
        end
      end
      CMD_DELETE: begin
        if (left_n == 0) r.status = ST_BOUND;
        else left_n--;
      end
      CMD_READ: begin
        if (e.idx >= len) r.status = ST_RANGE;
        else if (e.idx < left_n) r.char_out = shadow_text[e.idx];
        else r.char_out = shadow_text[DEPTH - len + e.idx];
      end
      default: ;
    endcase
    r.text_length = OUT_W'(left_n + right_n);
    r.cursor_pos  = OUT_W'(left_n);
    pending_results.push_back(r);
  endfunction

  function automatic edit_t mk(logic [CMD_W-1:0] c, logic [CHAR_W-1:0] ch,
                               logic [IDX_W-1:0] idx);
    edit_t e;
    e.cmd = c;
    e.ch  = ch;
    e.idx = idx;
    return e;
  endfunction

  // whatever is left after inserts, moves and deletes goes to reads, plus a few unused codes
  function automatic edit_t rand_edit(int unsigned ins_pct, int unsigned mov_pct,
                                      int unsigned del_pct);
    edit_t       e;
    int unsigned r;
    e.ch  = CHAR_W'($urandom_range(0, 255));
    e.idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 63))
                                 : IDX_W'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < ins_pct) e.cmd = CMD_INSERT;
    else if (r < ins_pct + mov_pct) e.cmd = $urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT;
    else if (r < ins_pct + mov_pct + del_pct) e.cmd = CMD_DELETE;
    else if (r < 97) e.cmd = CMD_READ;
    else e.cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    return e;
  endfunction

  // 0: sender 32% idle, receiver 76%; 1: the other way round; 2: no idling
  function automatic int traffic_phase();
    if (items_sent < total_items / 3) return 0;
    if (items_sent < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  task automatic diff_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : drive_cmds
    bit take_next;
    bit idle;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_edit(live_item);
        items_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        case (traffic_phase())
          0: idle = $urandom_range(0, 99) < 32;
          1: idle = $urandom_range(0, 99) < 76;
          default: idle = 1'b0;
        endcase
        // one pause that lets everything outstanding come back
        if (items_sent == DRAIN_AT && pending_results.size() != 0) idle = 1'b1;
        take_next = cmd_queue.size() != 0 && !idle;
        if (take_next) begin
          live_item = cmd_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.cmd        <= live_item.cmd;
          in_ch.char_in    <= live_item.ch;
          in_ch.read_index <= live_item.idx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    ctb_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual len %0d pos %0d status %0d",
                   $time, out_ch.text_length, out_ch.cursor_pos, out_ch.status);
        end else begin
          want = pending_results.pop_front();
          diff_field("char_out", want.char_out, out_ch.char_out);
          diff_field("text_length", want.text_length, out_ch.text_length);
          diff_field("cursor_pos", want.cursor_pos, out_ch.cursor_pos);
          diff_field("status", want.status, out_ch.status);
        end
        results_seen++;
        // long hold-off so the block backs up into its input
        if (results_seen == HOLD_AT) hold_cycles = HOLD_LEN;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        case (traffic_phase())
          0: out_ch.ready <= $urandom_range(0, 99) >= 76;
          1: out_ch.ready <= $urandom_range(0, 99) >= 32;
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("cursor_text_buffer_tb: errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INSERT;
    in_ch.char_in = '0;
    in_ch.read_index = '0;
    out_ch.ready = 1'b0;
    left_n = 0;
    right_n = 0;
    items_sent = 0;
    results_seen = 0;
    hold_cycles = 0;
    errors = 0;

    // empty buffer: every boundary case and the unused codes
    cmd_queue.push_back(mk(CMD_LEFT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_RIGHT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_DELETE, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd0));
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
      cmd_queue.push_back(mk(CMD_W'(c), 8'hFF, 10'h3FF));
    cmd_queue.push_back(mk(CMD_INSERT, 8'h00, 10'h3FF));
    cmd_queue.push_back(mk(CMD_INSERT, 8'hFF, 10'd0));
    cmd_queue.push_back(mk(CMD_INSERT, 8'hA5, 10'd0));
    cmd_queue.push_back(mk(CMD_INSERT, 8'h5A, 10'd0));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd3));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd4));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'h3FF));
    // put text on both sides of the gap, then read across it
    cmd_queue.push_back(mk(CMD_LEFT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_LEFT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd1));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd3));
    cmd_queue.push_back(mk(CMD_DELETE, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_RIGHT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_RIGHT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_RIGHT, 8'h00, 10'd0));

    for (int i = 0; i < 180; i++) cmd_queue.push_back(rand_edit(40, 30, 10));

    // long run of inserts with moves, reads and unused codes mixed in, no deletes
    for (int i = 0; i < 300; i++) begin
      cmd_queue.push_back(mk(CMD_INSERT, CHAR_W'($urandom_range(0, 255)),
                             IDX_W'($urandom_range(0, 1023))));
      if (i % 8 == 7) cmd_queue.push_back(rand_edit(0, 60, 0));
    end
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'h3FF));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_LEFT, 8'h00, 10'd0));
    cmd_queue.push_back(mk(CMD_INSERT, 8'hC3, 10'd0));
    cmd_queue.push_back(mk(CMD_READ, 8'h00, 10'h3FF));

    for (int i = 0; i < 60; i++) cmd_queue.push_back(rand_edit(10, 20, 45));
    for (int i = 0; i < 50; i++) cmd_queue.push_back(rand_edit(30, 30, 15));
    total_items = cmd_queue.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("cursor_text_buffer_tb: clean");
    end else begin
      $display("cursor_text_buffer_tb: errors");
    end
    $finish;
  end

endmodule

### cursor_text_buffer.f
sv/ctb_pkg.sv
sv/ctb_if.sv
sv/ctb_ram.sv
sv/ctb_ctrl.sv
sv/cursor_text_buffer.sv
tb/sv/cursor_text_buffer_tb.sv
